FILE: hw/rtl/tcc_pkg.sv
// Shared types and constants for the triangle circumcenter core.
`timescale 1ns / 1ps
package tcc_pkg;
	localparam int COORD_BITS = 16;
	localparam int OUT_BITS = 48;
	localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_COLLINEAR = 2'd1,
		ST_SATURATED = 2'd2
	} tcc_status_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] p_x;
		logic signed [COORD_BITS-1:0] p_y;
		logic signed [COORD_BITS-1:0] q_x;
		logic signed [COORD_BITS-1:0] q_y;
		logic signed [COORD_BITS-1:0] r_x;
		logic signed [COORD_BITS-1:0] r_y;
	} tcc_points_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] center_x;
		logic signed [OUT_BITS-1:0] center_y;
		tcc_status_t status;
	} tcc_center_t;
endpackage

FILE: hw/rtl/tcc_div_cell.sv
// One restoring division cell: one quotient bit for each of the x and y lanes.
`timescale 1ns / 1ps
module tcc_div_cell #(
	parameter int RB = 36,
	parameter int NW = 68
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RB-1:0] den_i,
	input  logic [RB-1:0] rem_x_i,
	input  logic [NW-1:0] word_x_i,
	input  logic [RB-1:0] rem_y_i,
	input  logic [NW-1:0] word_y_i,
	output logic [RB-1:0] den_o,
	output logic [RB-1:0] rem_x_o,
	output logic [NW-1:0] word_x_o,
	output logic [RB-1:0] rem_y_o,
	output logic [NW-1:0] word_y_o
);
	logic [RB:0] tx, ty, dx, dy;
	logic gex, gey;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_comb begin
		tx = {rem_x_i, word_x_i[NW-1]};
		ty = {rem_y_i, word_y_i[NW-1]};
		gex = tx >= {1'b0, den_i};
		gey = ty >= {1'b0, den_i};
		dx = tx - {1'b0, den_i};
		dy = ty - {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_x_o <= gex ? dx[RB-1:0] : tx[RB-1:0];
			rem_y_o <= gey ? dy[RB-1:0] : ty[RB-1:0];
			word_x_o <= {word_x_i[NW-2:0], gex};
			word_y_o <= {word_y_i[NW-2:0], gey};
		end
	end
endmodule

FILE: hw/rtl/triangle_circumcenter_core.sv
// Circumcenter of three integer points in fixed point, with a bit-per-cell divider row.
// Pipeline from transfer in to result, in this order:
// four arithmetic stages, one divider cell per quotient bit, one rounding stage.
// Throughput: one triangle per cycle; the whole pipeline holds while the result is stalled.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
module triangle_circumcenter_core
	import tcc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pt_valid,
	output logic        pt_stall,
	input  tcc_points_t pt,
	output logic        cc_valid,
	input  logic        cc_stall,
	output tcc_center_t cc
);
	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int CB = 2 * C + 2;
	localparam int DTB = 2 * C + 3;
	localparam int MB = D + CB;
	localparam int NB = 3 * C + 4;
	localparam int RB = 2 * C + 4;
	localparam int NW = NB + FRAC_BITS;

	logic adv;
	assign adv = !cc_valid || !cc_stall;
	assign pt_stall = !adv;

	// Stage 1: edge vectors and squares.
	logic v_s1;
	logic signed [D-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*C-1:0] spx_s1, spy_s1, sqx_s1, sqy_s1, srx_s1, sry_s1;
	// Stage 2: doubled bisector constants and determinant products.
	logic v_s2;
	logic signed [D-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CB-1:0] c1_s2, c2_s2;
	logic signed [2*D-1:0] pab_s2, pba_s2;
	// Stage 3: numerator products and determinant.
	logic v_s3;
	logic signed [MB-1:0] m1_s3, m2_s3, m3_s3, m4_s3;
	logic signed [DTB-1:0] det_s3;
	// Stage 4: magnitudes and signs handed to the divider row.
	logic v_s4, negx_s4, negy_s4, col_s4;
	logic [NB-1:0] magx_s4, magy_s4;
	logic [RB-1:0] den_s4;

	logic signed [NB-1:0] nx, ny;
	logic [DTB-1:0] absdet;
	always_comb begin
		nx = NB'(m1_s3) - NB'(m2_s3);
		ny = NB'(m3_s3) - NB'(m4_s3);
		absdet = det_s3[DTB-1] ? DTB'(-det_s3) : DTB'(det_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1 <= D'(pt.q_x) - D'(pt.p_x);
			b1_s1 <= D'(pt.q_y) - D'(pt.p_y);
			a2_s1 <= D'(pt.r_x) - D'(pt.q_x);
			b2_s1 <= D'(pt.r_y) - D'(pt.q_y);
			spx_s1 <= (2*C)'(pt.p_x) * (2*C)'(pt.p_x);
			spy_s1 <= (2*C)'(pt.p_y) * (2*C)'(pt.p_y);
			sqx_s1 <= (2*C)'(pt.q_x) * (2*C)'(pt.q_x);
			sqy_s1 <= (2*C)'(pt.q_y) * (2*C)'(pt.q_y);
			srx_s1 <= (2*C)'(pt.r_x) * (2*C)'(pt.r_x);
			sry_s1 <= (2*C)'(pt.r_y) * (2*C)'(pt.r_y);

			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			c1_s2 <= CB'(sqx_s1) - CB'(spx_s1) + CB'(sqy_s1) - CB'(spy_s1);
			c2_s2 <= CB'(srx_s1) - CB'(sqx_s1) + CB'(sry_s1) - CB'(sqy_s1);
			pab_s2 <= (2*D)'(a1_s1) * (2*D)'(b2_s1);
			pba_s2 <= (2*D)'(a2_s1) * (2*D)'(b1_s1);

			m1_s3 <= MB'(b2_s2) * MB'(c1_s2);
			m2_s3 <= MB'(b1_s2) * MB'(c2_s2);
			m3_s3 <= MB'(a1_s2) * MB'(c2_s2);
			m4_s3 <= MB'(a2_s2) * MB'(c1_s2);
			det_s3 <= DTB'(pab_s2) - DTB'(pba_s2);

			magx_s4 <= nx[NB-1] ? NB'(-nx) : NB'(nx);
			magy_s4 <= ny[NB-1] ? NB'(-ny) : NB'(ny);
			negx_s4 <= nx[NB-1] ^ det_s3[DTB-1];
			negy_s4 <= ny[NB-1] ^ det_s3[DTB-1];
			col_s4 <= det_s3 == '0;
			den_s4 <= {absdet, 1'b0};
		end
	end

	// Divider row: tap 0 is the row input, tap NW the finished quotient.
	logic [RB-1:0] den_c [0:NW];
	logic [RB-1:0] rem_x_c [0:NW];
	logic [RB-1:0] rem_y_c [0:NW];
	logic [NW-1:0] word_x_c [0:NW];
	logic [NW-1:0] word_y_c [0:NW];
	logic v_c [0:NW];
	logic negx_c [0:NW];
	logic negy_c [0:NW];
	logic col_c [0:NW];

	assign den_c[0] = den_s4;
	assign rem_x_c[0] = '0;
	assign rem_y_c[0] = '0;
	assign word_x_c[0] = NW'(magx_s4) << FRAC_BITS;
	assign word_y_c[0] = NW'(magy_s4) << FRAC_BITS;
	assign v_c[0] = v_s4;
	assign negx_c[0] = negx_s4;
	assign negy_c[0] = negy_s4;
	assign col_c[0] = col_s4;

	for (genvar i = 0; i < NW; i++) begin : g_row
		tcc_div_cell #(.RB(RB), .NW(NW)) u_cell (
			.clk     (clk),
			.en      (adv),
			.den_i   (den_c[i]),
			.rem_x_i (rem_x_c[i]),
			.word_x_i(word_x_c[i]),
			.rem_y_i (rem_y_c[i]),
			.word_y_i(word_y_c[i]),
			.den_o   (den_c[i+1]),
			.rem_x_o (rem_x_c[i+1]),
			.word_x_o(word_x_c[i+1]),
			.rem_y_o (rem_y_c[i+1]),
			.word_y_o(word_y_c[i+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[i+1] <= 1'b0;
			end else if (adv) begin
				v_c[i+1] <= v_c[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				negx_c[i+1] <= negx_c[i];
				negy_c[i+1] <= negy_c[i];
				col_c[i+1] <= col_c[i];
			end
		end
	end

	// Round half away from zero, then saturate to the output range.
	logic [NW:0] qx, qy;
	logic satx, saty;
	logic [OUT_BITS-1:0] ox, oy;
	always_comb begin
		qx = {1'b0, word_x_c[NW]} +
			(NW+1)'({rem_x_c[NW], 1'b0} >= {1'b0, den_c[NW]});
		qy = {1'b0, word_y_c[NW]} +
			(NW+1)'({rem_y_c[NW], 1'b0} >= {1'b0, den_c[NW]});
		if (negx_c[NW]) begin
			satx = qx > (NW+1)'(OUT_MIN);
			ox = satx ? OUT_MIN : OUT_BITS'(-qx[OUT_BITS-1:0]);
		end else begin
			satx = qx > (NW+1)'(OUT_MAX);
			ox = satx ? OUT_MAX : qx[OUT_BITS-1:0];
		end
		if (negy_c[NW]) begin
			saty = qy > (NW+1)'(OUT_MIN);
			oy = saty ? OUT_MIN : OUT_BITS'(-qy[OUT_BITS-1:0]);
		end else begin
			saty = qy > (NW+1)'(OUT_MAX);
			oy = saty ? OUT_MAX : qy[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_valid <= 1'b0;
		end else if (adv) begin
			cc_valid <= v_c[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (col_c[NW]) begin
				cc.center_x <= OUT_MAX;
				cc.center_y <= OUT_MAX;
				cc.status <= ST_COLLINEAR;
			end else begin
				cc.center_x <= ox;
				cc.center_y <= oy;
				cc.status <= (satx || saty) ? ST_SATURATED : ST_VALID;
			end
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall == (cc_valid && cc_stall))
		else $error("input stall does not follow the output register");
	a_collinear_max: assert property (@(posedge clk) disable iff (!arst_n)
		cc_valid && cc.status == ST_COLLINEAR |->
		cc.center_x == OUT_MAX && cc.center_y == OUT_MAX)
		else $error("collinear result not at the largest value");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		cc_valid |-> cc.status == ST_VALID || cc.status == ST_COLLINEAR ||
		cc.status == ST_SATURATED)
		else $error("unused status code on the output");
	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!cc_stall |=> cc_valid == $past(v_c[NW]))
		else $error("result valid lost or invented at the output");
`endif
endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the triangle circumcenter core: directed and random triangles.
`timescale 1ns / 1ps
module tb_top
	import tcc_pkg::*;
();

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic pt_valid;
	logic pt_stall;
	tcc_points_t pt;
	logic cc_valid;
	logic cc_stall;
	tcc_center_t cc;

	tcc_center_t centers_due[$];
	int idle_pct;
	int stall_pct;
	int errors;
	int cycles;

	triangle_circumcenter_core #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt),
		.cc_valid(cc_valid),
		.cc_stall(cc_stall),
		.cc(cc)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exact quotient with round-half-away-from-zero, saturated to the output range.
	function automatic logic [OUT_BITS-1:0] scaled_quotient(logic signed [127:0] num,
			logic signed [127:0] det, ref bit sat);
		logic [127:0] mag;
		logic [127:0] den;
		logic [127:0] quo;
		logic [127:0] rem;
		bit neg;
		neg = (num < 0) ^ (det < 0);
		mag = (num < 0) ? -num : num;
		den = ((det < 0) ? -det : det) * 2;
		mag = mag << FRAC;
		quo = mag / den;
		rem = mag % den;
		if (rem * 2 >= den)
			quo = quo + 1;
		if (!neg) begin
			if (quo > {80'd0, OUT_MAX}) begin
				sat = 1'b1;
				return OUT_MAX;
			end
			return quo[OUT_BITS-1:0];
		end
		if (quo > {80'd0, OUT_MAX} + 1) begin
			sat = 1'b1;
			return OUT_MIN;
		end
		quo = -quo;
		return quo[OUT_BITS-1:0];
	endfunction

	function automatic tcc_center_t circumcenter(tcc_points_t t);
		logic signed [127:0] px, py, qx, qy, rx, ry;
		logic signed [127:0] a1, b1, a2, b2, c1, c2, det;
		tcc_center_t res;
		bit sat;
		px = t.p_x; py = t.p_y; qx = t.q_x; qy = t.q_y; rx = t.r_x; ry = t.r_y;
		a1 = qx - px; b1 = qy - py;
		a2 = rx - qx; b2 = ry - qy;
		c1 = (qx * qx - px * px) + (qy * qy - py * py);
		c2 = (rx * rx - qx * qx) + (ry * ry - qy * qy);
		det = a1 * b2 - a2 * b1;
		sat = 1'b0;
		if (det == 0) begin
			res.center_x = OUT_MAX;
			res.center_y = OUT_MAX;
			res.status = ST_COLLINEAR;
			return res;
		end
		res.center_x = scaled_quotient(b2 * c1 - b1 * c2, det, sat);
		res.center_y = scaled_quotient(a1 * c2 - a2 * c1, det, sat);
		res.status = sat ? ST_SATURATED : ST_VALID;
		return res;
	endfunction

	always @(posedge clk) begin
		cc_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		tcc_center_t want;
		if (arst_n && cc_valid && !cc_stall) begin
			if (centers_due.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				want = centers_due.pop_front();
				if (cc.center_x !== want.center_x) begin
					$error("center_x expected %0d actual %0d", want.center_x, cc.center_x);
					errors++;
				end
				if (cc.center_y !== want.center_y) begin
					$error("center_y expected %0d actual %0d", want.center_y, cc.center_y);
					errors++;
				end
				if (cc.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, cc.status);
					errors++;
				end
			end
		end
	end

	task automatic send_points(tcc_points_t t);
		pt_valid <= 1'b1;
		pt <= t;
		forever begin
			@(posedge clk);
			if (!pt_stall)
				break;
		end
		centers_due.push_back(circumcenter(t));
		if ($urandom_range(0, 99) < idle_pct) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic tcc_points_t make_points(int ax, int ay, int bx, int by, int cx, int cy);
		tcc_points_t t;
		t.p_x = COORD_BITS'(ax);
		t.p_y = COORD_BITS'(ay);
		t.q_x = COORD_BITS'(bx);
		t.q_y = COORD_BITS'(by);
		t.r_x = COORD_BITS'(cx);
		t.r_y = COORD_BITS'(cy);
		return t;
	endfunction

	task automatic test_directed();
		send_points(make_points(0, 0, 4, 0, 0, 4));
		send_points(make_points(0, 0, 1, 0, 0, 1));
		send_points(make_points(-32768, -32768, 32767, -32768, -32768, 32767));
		send_points(make_points(32767, 32767, -32768, 32767, 32767, -32768));
		send_points(make_points(-32768, 32767, 32767, -32768, 32767, 32767));
		// Collinear, then fully or partly coincident points.
		send_points(make_points(0, 0, 1, 1, 2, 2));
		send_points(make_points(-32768, -32768, 0, 0, 32767, 32767));
		send_points(make_points(5, 5, 5, 5, 5, 5));
		send_points(make_points(3, 4, 3, 4, 7, 9));
		send_points(make_points(-32768, -32768, -32768, -32768, -32768, -32768));
		// Nearly collinear with long sides: the center still lies inside the output range.
		send_points(make_points(-32768, -32768, 32767, 32767, 32767, 32766));
		send_points(make_points(-32768, -32768, 32767, 32767, 32766, 32767));
		send_points(make_points(-32768, 0, 32767, 0, 0, 1));
		send_points(make_points(-32768, 0, 32767, 0, 0, -1));
		send_points(make_points(1, 0, 0, 1, -1, 0));
		send_points(make_points(0, 0, 3, 0, 0, 1));
		send_points(make_points(0, 0, 2, 0, 1, 3));
		send_points(make_points(0, 0, 32767, 1, -32768, 2));
	endtask

	task automatic test_random(int count);
		int ax, ay, dx, dy, k1, k2, span;
		repeat (count) begin
			case ($urandom_range(0, 4))
				0: send_points(tcc_points_t'({$urandom, $urandom, $urandom}));
				1: begin
					span = $urandom_range(1, 60);
					send_points(make_points($urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span));
				end
				2: begin
					ax = $urandom_range(0, 2000) - 1000; ay = $urandom_range(0, 2000) - 1000;
					dx = $urandom_range(0, 20) - 10; dy = $urandom_range(0, 20) - 10;
					k1 = $urandom_range(0, 8) - 4; k2 = $urandom_range(0, 8) - 4;
					send_points(make_points(ax, ay, ax + k1 * dx, ay + k1 * dy,
						ax + k2 * dx, ay + k2 * dy));
				end
				3: begin
					// Two points mirrored through the origin and a third at most one step from the second.
					ax = $urandom_range(0, 65535) - 32768; ay = $urandom_range(0, 65535) - 32768;
					send_points(make_points(ax, ay, -ax - 1, -ay - 1,
						-ax - 1 + $urandom_range(0, 2) - 1, -ay - 1 + $urandom_range(0, 2) - 1));
				end
				default: begin
					span = $urandom_range(100, 32767);
					send_points(make_points($urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span));
				end
			endcase
		end
	endtask

	task automatic drain();
		pt_valid <= 1'b0;
		while (centers_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pt = '0;
		cc_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(280);
		idle_pct = 67;
		test_random(280);
		idle_pct = 0;
		stall_pct = 67;
		test_random(280);
		idle_pct = 26;
		stall_pct = 26;
		test_random(290);
		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
